// ===== src/dcas_pkg.sv =====
package dcas_pkg;

    localparam int MaxLayers = 256;
    localparam int LayerW    = 8;
    localparam int FieldW    = 16;
    localparam int EnergyW   = 48;
    localparam int CfgIdxW   = 1;

    // shared multiplier: 32 x 16 -> 48
    localparam int MulAW = 32;
    localparam int MulBW = 16;
    localparam int ProdW = MulAW + MulBW;

    // parabola fit division: quotient never exceeds 128
    localparam int QBits     = 9;
    localparam int QCntW     = $clog2(QBits);
    localparam int DividendW = EnergyW + 9;
    localparam int DivisorW  = EnergyW + 2;
    localparam int ShiftW    = DivisorW + QBits - 1;

    typedef logic [LayerW-1:0]  layer_t;
    typedef logic [FieldW-1:0]  field_t;
    typedef logic [EnergyW-1:0] energy_t;

    localparam layer_t  LastLayer = LayerW'(MaxLayers - 1);
    localparam energy_t EnergyMax = '1;
    localparam field_t  CoefReset = FieldW'(256);

    typedef enum logic [CfgIdxW-1:0] {
        REG_QUAD_COEF     = 1'b0,
        REG_LAMBDA_WEIGHT = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== src/dcas_in_if.sv =====
interface dcas_in_if;
    import dcas_pkg::*;

    logic   valid;
    logic   ready;
    field_t cost;
    field_t depth_estimate;
    logic   last;

    modport source (output valid, output cost, output depth_estimate, output last,
                    input ready);
    modport sink (input valid, input cost, input depth_estimate, input last,
                  output ready);
endinterface

// ===== src/dcas_out_if.sv =====
interface dcas_out_if;
    import dcas_pkg::*;

    logic   valid;
    logic   ready;
    field_t new_depth;
    layer_t best_layer;
    logic   at_edge;

    modport source (output valid, output new_depth, output best_layer, output at_edge,
                    input ready);
    modport sink (input valid, input new_depth, input best_layer, input at_edge,
                  output ready);
endinterface

// ===== src/dcas_div.sv =====
module dcas_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [dcas_pkg::DividendW-1:0]     dividend,
    input  logic [dcas_pkg::DivisorW-1:0]      divisor,
    output dcas_pkg::div_stat_t                stat,
    output logic [dcas_pkg::QBits-1:0]         quotient
);
    import dcas_pkg::*;

    logic [DividendW-1:0] rem_reg;
    logic [ShiftW-1:0]    ds_reg;
    logic [QBits-1:0]     q_reg;
    logic [QCntW-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic                 fits;
    logic [ShiftW-1:0]    rem_diff;

    // restoring division, one quotient bit a cycle, msb first
    assign fits     = ShiftW'(rem_reg) >= ds_reg;
    assign rem_diff = ShiftW'(rem_reg) - ds_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            ds_reg   <= '0;
            q_reg    <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg  <= dividend;
                ds_reg   <= {divisor, {(QBits-1){1'b0}}};
                q_reg    <= '0;
                cnt_reg  <= QCntW'(QBits - 1);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (fits)
                begin
                    rem_reg <= rem_diff[DividendW-1:0];
                end
                q_reg  <= {q_reg[QBits-2:0], fits};
                ds_reg <= ds_reg >> 1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = q_reg;

endmodule

// ===== src/depth_cost_argmin_subsample.sv =====
// each sample goes through the transfer, three passes through one shared 32x16 multiplier,
// then the energy compare; samples.ready is low after a transfer until the state is idle again
// a last sample then adds S_SETUP and S_FINISH at an edge minimum, with S_DIV between them when
// the parabola fit runs (9-step bit-serial divider); the result is loaded in S_FINISH
// the result sits in an output register, so the next pixel may start while it waits
// rst_n clears the pixel state and sets both weights to 1.0; no clearing pass
module depth_cost_argmin_subsample (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  dcas_pkg::cfg_idx_t    cfg_index,
    input  dcas_pkg::field_t      cfg_data,
    dcas_in_if.sink               samples,
    dcas_out_if.source            results
);
    import dcas_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_LAM,
        S_MUL_SQ,
        S_MUL_QUAD,
        S_UPDATE,
        S_SETUP,
        S_DIV,
        S_FINISH
    } state_t;

    state_t  state_reg;

    field_t  quad_coef_reg;
    field_t  lambda_weight_reg;

    // latched sample
    field_t  cost_reg;
    logic    last_reg;
    logic    first_reg;
    logic    skip_reg;
    layer_t  idx_reg;

    // pixel state
    logic    in_pixel_reg;
    layer_t  layer_count_reg;
    field_t  held_depth_reg;
    energy_t best_energy_reg;
    layer_t  best_index_reg;
    energy_t energy_before_best_reg;
    energy_t energy_after_best_reg;
    energy_t previous_energy_reg;
    logic    awaiting_after_reg;

    // arithmetic
    logic [ProdW-1:0] prod_reg;
    logic [MulAW-1:0] acc_reg;
    logic [QBits-1:0] q_reg;
    logic             neg_reg;
    logic             edge_reg;

    // output register
    logic    out_valid_reg;
    field_t  new_depth_reg;
    layer_t  best_layer_reg;
    logic    at_edge_reg;

    logic [MulAW-1:0]  mul_a;
    logic [MulBW-1:0]  mul_b;
    logic [ProdW-1:0]  mul_prod;
    logic [FieldW:0]   diff;
    field_t            mag;
    logic [EnergyW:0]  sum;
    energy_t           energy;

    logic              accept;
    logic              min_at_edge;
    logic              fit_ok;
    logic [DivisorW-1:0]  den;
    logic                 c_above_a;
    energy_t              span;
    logic [DividendW-1:0] dividend;
    logic [DivisorW-1:0]  divisor;
    logic                 div_start;
    div_stat_t            div_stat;
    logic [QBits-1:0]     quotient;

    logic [FieldW:0]   base;
    logic [FieldW:0]   off;
    logic [FieldW:0]   shifted;
    logic [FieldW:0]   limit;
    logic [FieldW:0]   nd;
    logic              out_free;

    assign accept   = samples.valid && samples.ready;
    assign out_free = !out_valid_reg || results.ready;

    // distance between depth estimate and layer in Q8.8
    assign diff = {1'b0, held_depth_reg} - {1'b0, idx_reg, 8'h00};
    always_comb
    begin
        if (diff[FieldW])
        begin
            mag = FieldW'(-diff);
        end
        else
        begin
            mag = diff[FieldW-1:0];
        end
    end

    always_comb
    begin
        case (state_reg)
            S_MUL_LAM:
            begin
                mul_a = MulAW'(cost_reg);
                mul_b = lambda_weight_reg;
            end
            S_MUL_SQ:
            begin
                mul_a = MulAW'(mag);
                mul_b = mag;
            end
            S_MUL_QUAD:
            begin
                mul_a = prod_reg[MulAW-1:0];
                mul_b = quad_coef_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_prod = ProdW'(mul_a) * ProdW'(mul_b);

    // quad term plus cost term scaled up to 24 fraction bits, saturated
    assign sum    = {1'b0, prod_reg} + (EnergyW+1)'({acc_reg, 8'h00});
    assign energy = sum[EnergyW] ? EnergyMax : sum[EnergyW-1:0];

    // parabola through the energies around the minimum
    assign min_at_edge = (best_index_reg == '0) || (best_index_reg == layer_count_reg);
    assign den = DivisorW'(energy_before_best_reg) - DivisorW'(best_energy_reg)
               + DivisorW'(energy_after_best_reg) - DivisorW'(best_energy_reg);
    assign fit_ok = (energy_before_best_reg >= best_energy_reg)
                 && (energy_after_best_reg >= best_energy_reg) && (den != '0);
    assign c_above_a = energy_before_best_reg < energy_after_best_reg;
    assign span = c_above_a ? energy_after_best_reg - energy_before_best_reg
                            : energy_before_best_reg - energy_after_best_reg;
    assign dividend  = DividendW'({span, 8'h00}) + DividendW'(den);
    assign divisor   = {den[DivisorW-2:0], 1'b0};
    assign div_start = (state_reg == S_SETUP) && !min_at_edge && fit_ok;

    dcas_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .stat     (div_stat),
        .quotient (quotient)
    );

    // rounded offset applied to the integer layer, clamped to the layer range
    assign base    = {1'b0, best_index_reg, 8'h00};
    assign off     = (FieldW+1)'(q_reg);
    assign limit   = {1'b0, layer_count_reg, 8'h00};
    always_comb
    begin
        if (neg_reg)
        begin
            shifted = (off > base) ? '0 : base - off;
        end
        else
        begin
            shifted = base + off;
        end
        nd = (shifted > limit) ? limit : shifted;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg              <= S_IDLE;
            quad_coef_reg          <= CoefReset;
            lambda_weight_reg      <= CoefReset;
            cost_reg               <= '0;
            last_reg               <= 1'b0;
            first_reg              <= 1'b0;
            skip_reg               <= 1'b0;
            idx_reg                <= '0;
            in_pixel_reg           <= 1'b0;
            layer_count_reg        <= '0;
            held_depth_reg         <= '0;
            best_energy_reg        <= EnergyMax;
            best_index_reg         <= '0;
            energy_before_best_reg <= '0;
            energy_after_best_reg  <= '0;
            previous_energy_reg    <= '0;
            awaiting_after_reg     <= 1'b0;
            prod_reg               <= '0;
            acc_reg                <= '0;
            q_reg                  <= '0;
            neg_reg                <= 1'b0;
            edge_reg               <= 1'b0;
            out_valid_reg          <= 1'b0;
            new_depth_reg          <= '0;
            best_layer_reg         <= '0;
            at_edge_reg            <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_QUAD_COEF:     quad_coef_reg     <= cfg_data;
                    REG_LAMBDA_WEIGHT: lambda_weight_reg <= cfg_data;
                    default:           ;
                endcase
            end

            // in S_FINISH the output register is reloaded below instead
            if (out_valid_reg && results.ready && (state_reg != S_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cost_reg  <= samples.cost;
                        last_reg  <= samples.last;
                        first_reg <= !in_pixel_reg;
                        skip_reg  <= in_pixel_reg && (layer_count_reg == LastLayer);
                        if (!in_pixel_reg)
                        begin
                            held_depth_reg <= samples.depth_estimate;
                            idx_reg        <= '0;
                        end
                        else
                        begin
                            idx_reg <= layer_count_reg + 1'b1;
                        end
                        state_reg <= S_MUL_LAM;
                    end
                end
                S_MUL_LAM:
                begin
                    prod_reg  <= mul_prod;
                    state_reg <= S_MUL_SQ;
                end
                S_MUL_SQ:
                begin
                    acc_reg   <= prod_reg[MulAW-1:0];
                    prod_reg  <= mul_prod;
                    state_reg <= S_MUL_QUAD;
                end
                S_MUL_QUAD:
                begin
                    prod_reg  <= mul_prod;
                    state_reg <= S_UPDATE;
                end
                S_UPDATE:
                begin
                    if (first_reg)
                    begin
                        layer_count_reg        <= '0;
                        best_energy_reg        <= energy;
                        best_index_reg         <= '0;
                        energy_before_best_reg <= '0;
                        energy_after_best_reg  <= '0;
                        previous_energy_reg    <= energy;
                        awaiting_after_reg     <= 1'b1;
                        in_pixel_reg           <= 1'b1;
                    end
                    else if (!skip_reg)
                    begin
                        layer_count_reg     <= idx_reg;
                        previous_energy_reg <= energy;
                        if (energy < best_energy_reg)
                        begin
                            energy_before_best_reg <= previous_energy_reg;
                            best_energy_reg        <= energy;
                            best_index_reg         <= idx_reg;
                            awaiting_after_reg     <= 1'b1;
                        end
                        else if (awaiting_after_reg)
                        begin
                            energy_after_best_reg <= energy;
                            awaiting_after_reg    <= 1'b0;
                        end
                    end
                    state_reg <= last_reg ? S_SETUP : S_IDLE;
                end
                S_SETUP:
                begin
                    edge_reg <= min_at_edge;
                    if (div_start)
                    begin
                        neg_reg   <= c_above_a;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        q_reg     <= '0;
                        neg_reg   <= 1'b0;
                        state_reg <= S_FINISH;
                    end
                end
                S_DIV:
                begin
                    if (div_stat.done)
                    begin
                        q_reg     <= quotient;
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg          <= 1'b1;
                        new_depth_reg          <= nd[FieldW-1:0];
                        best_layer_reg         <= best_index_reg;
                        at_edge_reg            <= edge_reg;
                        // pixel done: back to the reset values
                        in_pixel_reg           <= 1'b0;
                        layer_count_reg        <= '0;
                        held_depth_reg         <= '0;
                        best_energy_reg        <= EnergyMax;
                        best_index_reg         <= '0;
                        energy_before_best_reg <= '0;
                        energy_after_best_reg  <= '0;
                        previous_energy_reg    <= '0;
                        awaiting_after_reg     <= 1'b0;
                        state_reg              <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign samples.ready      = (state_reg == S_IDLE);
    assign results.valid      = out_valid_reg;
    assign results.new_depth  = new_depth_reg;
    assign results.best_layer = best_layer_reg;
    assign results.at_edge    = at_edge_reg;

endmodule

// ===== src/dcas_checker.sv =====
module dcas_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input dcas_pkg::field_t  new_depth,
    input dcas_pkg::layer_t  best_layer,
    input logic              at_edge
);
    import dcas_pkg::*;

    logic [FieldW:0] centre;
    logic [FieldW:0] depth_ext;

    assign centre    = {1'b0, best_layer, 8'h00};
    assign depth_ext = {1'b0, new_depth};

    // a sample keeps the shared unit busy after its transfer
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken on the cycle after a transfer");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(new_depth)
            && $stable(best_layer) && $stable(at_edge)))
        else $error("stalled result changed");

    // edge minimum is reported unrefined
    a_edge_integer: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && at_edge) |-> (depth_ext == centre))
        else $error("edge result not on integer layer");

    // refinement stays within half a layer of the integer minimum
    a_refine_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !at_edge) |-> ((best_layer != '0)
            && (depth_ext + 17'd128 >= centre) && (depth_ext <= centre + 17'd128)))
        else $error("refined depth out of range");

endmodule

bind depth_cost_argmin_subsample dcas_checker u_dcas_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (samples.valid),
    .in_ready   (samples.ready),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .new_depth  (results.new_depth),
    .best_layer (results.best_layer),
    .at_edge    (results.at_edge)
);

// ===== dv/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dcas_pkg::*;

    typedef struct packed {
        field_t cost;
        field_t depth;
        logic   last;
    } sample_t;

    typedef struct packed {
        field_t new_depth;
        layer_t best_layer;
        logic   at_edge;
    } depth_result_t;

    typedef enum int {
        SHAPE_VALLEY,
        SHAPE_NOISE,
        SHAPE_FLAT,
        SHAPE_LOW
    } cost_shape_t;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     cfg_we    = 1'b0;
    cfg_idx_t cfg_index = REG_QUAD_COEF;
    field_t   cfg_data  = '0;

    logic   in_valid  = 1'b0;
    field_t in_cost   = '0;
    field_t in_depth  = '0;
    logic   in_last   = 1'b0;
    logic   out_ready = 1'b0;

    // both sides stop idling while this is set
    bit steady = 1'b0;
    int errors = 0;

    sample_t       pending_samples[$];
    depth_result_t expected_depths[$];

    // weights as the block should hold them
    field_t quad_w   = CoefReset;
    field_t lambda_w = CoefReset;

    // per-pixel argmin tracking
    bit          trk_open  = 1'b0;
    int unsigned trk_top   = 0;
    int unsigned trk_index = 0;
    field_t      trk_depth = '0;
    logic [63:0] trk_best  = 64'(EnergyMax);
    logic [63:0] trk_before = '0;
    logic [63:0] trk_after = '0;
    logic [63:0] trk_prev  = '0;
    bit          trk_await = 1'b0;

    dcas_in_if  samples_if ();
    dcas_out_if results_if ();

    assign samples_if.valid          = in_valid;
    assign samples_if.cost           = in_cost;
    assign samples_if.depth_estimate = in_depth;
    assign samples_if.last           = in_last;
    assign results_if.ready          = out_ready;

    depth_cost_argmin_subsample DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (samples_if),
        .results   (results_if)
    );

    always #10 clk = ~clk;

    function automatic logic [63:0] layer_energy(field_t depth, int unsigned layer, field_t cost);
        longint      diff;
        logic [63:0] mag;
        logic [63:0] e;
        diff = longint'(depth) - longint'(layer) * 256;
        mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
        e    = 64'(quad_w) * (mag * mag) + ((64'(lambda_w) * 64'(cost)) << 8);
        return (e > 64'(EnergyMax)) ? 64'(EnergyMax) : e;
    endfunction

    function automatic bit track_sample(input sample_t s, output depth_result_t r);
        logic [63:0] e;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] den;
        logic [63:0] num;
        logic [63:0] off;
        logic [63:0] nd;
        bit          neg;
        bit          at_end;
        r = '0;
        if (!trk_open) begin
            trk_depth  = s.depth;
            trk_top    = 0;
            trk_best   = layer_energy(s.depth, 0, s.cost);
            trk_index  = 0;
            trk_before = '0;
            trk_after  = '0;
            trk_prev   = trk_best;
            trk_await  = 1'b1;
            trk_open   = 1'b1;
        end
        else if (trk_top < MaxLayers - 1) begin
            trk_top = trk_top + 1;
            e = layer_energy(trk_depth, trk_top, s.cost);
            if (e < trk_best) begin
                trk_before = trk_prev;
                trk_best   = e;
                trk_index  = trk_top;
                trk_await  = 1'b1;
            end
            else if (trk_await) begin
                trk_after = e;
                trk_await = 1'b0;
            end
            trk_prev = e;
        end
        if (!s.last)
            return 1'b0;

        nd     = 64'(trk_index) * 64'd256;
        at_end = 1'b0;
        if (trk_index == 0 || trk_index == trk_top) begin
            at_end = 1'b1;
        end
        else begin
            a   = trk_before;
            b   = trk_best;
            c   = trk_after;
            den = (a - b) + (c - b);
            if (a >= b && c >= b && den != 0) begin
                neg = (a < c);
                num = (neg ? c - a : a - c) * 64'd256;
                // parabola vertex, rounded half away from zero
                off = (num + den) / (64'd2 * den);
                if (neg)
                    nd = (off > nd) ? 64'd0 : nd - off;
                else
                    nd = nd + off;
            end
            if (nd > 64'(trk_top) * 64'd256)
                nd = 64'(trk_top) * 64'd256;
        end
        if (nd > 64'hFFFF)
            nd = 64'hFFFF;

        r.new_depth  = nd[15:0];
        r.best_layer = layer_t'(trk_index);
        r.at_edge    = at_end;
        trk_open     = 1'b0;
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quad_w   <= CoefReset;
            lambda_w <= CoefReset;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_QUAD_COEF:     quad_w   <= cfg_data;
                REG_LAMBDA_WEIGHT: lambda_w <= cfg_data;
                default:           ;
            endcase
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : drive_samples
        sample_t       cur;
        sample_t       nxt;
        depth_result_t res;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && samples_if.ready)
            begin
                cur.cost  = in_cost;
                cur.depth = in_depth;
                cur.last  = in_last;
                if (track_sample(cur, res))
                    expected_depths.push_back(res);
            end
            if (!in_valid || samples_if.ready)
            begin
                if (pending_samples.size() != 0 && (steady || $urandom_range(99) >= 22))
                begin
                    nxt = pending_samples.pop_front();
                    in_valid <= 1'b1;
                    in_cost  <= nxt.cost;
                    in_depth <= nxt.depth;
                    in_last  <= nxt.last;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : check_results
        depth_result_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (results_if.valid && out_ready)
            begin
                if (expected_depths.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result: new_depth %h best_layer %h at_edge %b",
                             $time, results_if.new_depth, results_if.best_layer,
                             results_if.at_edge);
                end
                else
                begin
                    want = expected_depths.pop_front();
                    if (results_if.new_depth !== want.new_depth)
                    begin
                        errors++;
                        $display("%0t: new_depth mismatch: expected %h actual %h",
                                 $time, want.new_depth, results_if.new_depth);
                    end
                    if (results_if.best_layer !== want.best_layer)
                    begin
                        errors++;
                        $display("%0t: best_layer mismatch: expected %h actual %h",
                                 $time, want.best_layer, results_if.best_layer);
                    end
                    if (results_if.at_edge !== want.at_edge)
                    begin
                        errors++;
                        $display("%0t: at_edge mismatch: expected %b actual %b",
                                 $time, want.at_edge, results_if.at_edge);
                    end
                end
            end
            out_ready <= steady || ($urandom_range(99) >= 22);
        end
    end

    task automatic push_sample(input int unsigned cost, input int unsigned depth,
                               input bit last);
        sample_t s;
        s.cost  = field_t'(cost);
        s.depth = field_t'(depth);
        s.last  = last;
        pending_samples.push_back(s);
    endtask

    task automatic push_pixel(input int unsigned n, input cost_shape_t shape);
        longint      centre;
        longint      scale;
        longint      delta;
        longint      v;
        int unsigned flat_cost;
        int unsigned span;
        int unsigned first_depth;
        int unsigned cost;
        centre    = $urandom_range(n - 1, 0);
        scale     = $urandom_range(4000, 1);
        flat_cost = ($urandom_range(3) == 0) ? (($urandom_range(1) == 0) ? 0 : 65535)
                                             : $urandom_range(65535, 0);
        span      = ((n > MaxLayers) ? MaxLayers - 1 : n - 1) * 256 + 255;
        if (span > 65535)
            span = 65535;
        first_depth = ($urandom_range(99) < 80) ? $urandom_range(span, 0)
                                                : $urandom_range(65535, 0);
        for (int unsigned i = 0; i < n; i++)
        begin
            case (shape)
                SHAPE_VALLEY:
                begin
                    delta = longint'(i) - centre;
                    v     = scale * delta * delta + longint'($urandom_range(scale, 0));
                    cost  = (v > 65535) ? 65535 : int'(v);
                end
                SHAPE_NOISE: cost = $urandom_range(65535, 0);
                SHAPE_FLAT:  cost = flat_cost;
                default:     cost = $urandom_range(3, 0);
            endcase
            // only the first depth is latched, the rest still toggle the field
            push_sample(cost, (i == 0) ? first_depth : $urandom_range(65535, 0), i == n - 1);
        end
    endtask

    task automatic push_random_pixel(output int unsigned n);
        int unsigned r;
        cost_shape_t shape;
        r = $urandom_range(99);
        if (r < 10)
            n = $urandom_range(2, 1);
        else if (r < 90)
            n = $urandom_range(16, 3);
        else
            n = $urandom_range(40, 17);
        r = $urandom_range(99);
        if (r < 60)
            shape = SHAPE_VALLEY;
        else if (r < 75)
            shape = SHAPE_NOISE;
        else if (r < 85)
            shape = SHAPE_FLAT;
        else
            shape = SHAPE_LOW;
        push_pixel(n, shape);
    endtask

    // wait until nothing is in flight, then let the block sit idle
    task automatic drain();
        while (pending_samples.size() != 0 || in_valid || expected_depths.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input int unsigned value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= field_t'(value);
        @(posedge clk);
    endtask

    task automatic set_weights(input int unsigned quad, input int unsigned lambda);
        write_reg(REG_QUAD_COEF, quad);
        write_reg(REG_LAMBDA_WEIGHT, lambda);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin : run
        int unsigned phase_items;
        int unsigned n;
        int unsigned q;
        int unsigned l;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset weights: single sample, interior minima both ways, edge at the top
        push_sample(65535, 65535, 1'b1);
        push_sample(200, 256, 1'b0);
        push_sample(0, 0, 1'b0);
        push_sample(10, 65535, 1'b1);
        push_sample(10, 256, 1'b0);
        push_sample(0, 0, 1'b0);
        push_sample(200, 0, 1'b1);
        push_sample(0, 512, 1'b0);
        push_sample(0, 0, 1'b0);
        push_sample(0, 0, 1'b1);
        push_sample(65535, 65535, 1'b0);
        push_sample(0, 0, 1'b0);
        push_sample(65535, 0, 1'b0);
        push_sample(0, 0, 1'b1);
        drain();

        // largest weights: layer 0 saturates the energy
        set_weights(65535, 65535);
        push_sample(65535, 65535, 1'b0);
        push_sample(65535, 0, 1'b0);
        push_sample(65535, 0, 1'b1);
        drain();

        // cost only: equal energies keep the first minimum
        set_weights(0, 256);
        push_sample(9, 1000, 1'b0);
        push_sample(5, 0, 1'b0);
        push_sample(5, 65535, 1'b1);
        drain();

        // distance only: estimate half way between two layers
        set_weights(256, 0);
        push_sample(65535, 384, 1'b0);
        push_sample(0, 0, 1'b0);
        push_sample(12345, 0, 1'b1);
        drain();

        for (int ph = 0; ph < 10; ph++)
        begin
            case (ph)
                0: begin q = 65535; l = 1;     end
                1: begin q = 1;     l = 65535; end
                2: begin q = 0;     l = 65535; end
                3: begin q = 65535; l = 0;     end
                4: begin q = 256;   l = 256;   end
                5: begin q = 0;     l = 0;     end
                default:
                begin
                    q = ($urandom_range(1) == 0) ? $urandom_range(1024, 0)
                                                 : $urandom_range(65535, 0);
                    l = ($urandom_range(1) == 0) ? $urandom_range(1024, 0)
                                                 : $urandom_range(65535, 0);
                end
            endcase
            set_weights(q, l);
            steady = (ph == 4);
            phase_items = 0;
            // full-length pixels, one overlong: extra samples are dropped, last one still ends it
            if (ph == 6)
            begin
                push_pixel(MaxLayers + 4, SHAPE_VALLEY);
                phase_items += MaxLayers;
            end
            if (ph == 7)
            begin
                push_pixel(MaxLayers, SHAPE_NOISE);
                phase_items += MaxLayers;
            end
            while (phase_items < 110)
            begin
                push_random_pixel(n);
                phase_items += n;
            end
            drain();
            steady = 1'b0;
        end

        repeat (40) @(posedge clk);
        if (expected_depths.size() != 0)
        begin
            errors += expected_depths.size();
            $display("%0t: %0d results never arrived", $time, expected_depths.size());
        end
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : watchdog
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
